// ===== rtl/s2u_pkg.sv =====
package s2u_pkg;

  localparam int CHAR_W      = 8;
  localparam int BASE_W      = 6;
  localparam int OUT_VALUE_W = 32;
  localparam int OFFSET_W    = 8;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [BASE_W-1:0] base;
    logic              minus;
    logic              digit_seen;
    logic              overflow;
  } ctl_t;

  localparam ctl_t CTL_CLEAR = '{
    phase:      PH_SKIP,
    base:       BASE_AUTO,
    minus:      1'b0,
    digit_seen: 1'b0,
    overflow:   1'b0
  };

endpackage

// ===== rtl/s2u_if.sv =====
interface s2u_in_if;
  logic                        valid;
  logic                        ready;
  logic [s2u_pkg::CHAR_W-1:0]  char_in;
  logic                        last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface s2u_out_if;
  logic                             valid;
  logic                             ready;
  logic [s2u_pkg::OUT_VALUE_W-1:0]  value;
  logic [s2u_pkg::OFFSET_W-1:0]     stop_offset;
  logic                             digits_taken;
  logic                             overflowed;

  modport source (output valid, output value, output stop_offset, output digits_taken,
                  output overflowed, input ready);
  modport sink   (input valid, input value, input stop_offset, input digits_taken,
                  input overflowed, output ready);
endinterface

interface s2u_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [s2u_pkg::BASE_W-1:0]  number_base;

  modport source (output valid, output number_base, input ready);
  modport sink   (input valid, input number_base, output ready);
endinterface

// ===== rtl/s2u_step.sv =====
module s2u_step #(
  parameter int VALUE_BITS = 32
) (
  input  logic [s2u_pkg::CHAR_W-1:0] char_in,
  input  logic                       last_char,
  input  s2u_pkg::ctl_t              ctl,
  input  logic [VALUE_BITS-1:0]      acc,
  input  logic [s2u_pkg::BASE_W-1:0] cfg_base,
  output s2u_pkg::ctl_t              ctl_nxt,
  output logic [VALUE_BITS-1:0]      acc_nxt,
  output logic                       stop,
  output logic                       term
);

  localparam int PW = VALUE_BITS + s2u_pkg::BASE_W;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] NOT_DIGIT = 8'hFF;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = NOT_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      v = c - CH_UA + LETTER_OFS;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      v = c - CH_LA + LETTER_OFS;
    end
    return v;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  logic          sign_path;
  logic          take;
  logic          stop_c;
  logic [7:0]    dv;
  logic          is_dig;
  logic [PW-1:0] prod;

  always_comb begin
    ctl_nxt   = ctl;
    acc_nxt   = acc;
    sign_path = 1'b0;
    take      = 1'b0;
    stop_c    = 1'b0;

    case (ctl.phase)
      s2u_pkg::PH_SKIP: begin
        if (!is_space(char_in)) begin
          ctl_nxt.phase = s2u_pkg::PH_SIGN;
          if (char_in == CH_MINUS) begin
            ctl_nxt.minus = 1'b1;
          end else if (char_in != CH_PLUS) begin
            sign_path = 1'b1;
          end
        end
      end
      s2u_pkg::PH_SIGN: begin
        sign_path = 1'b1;
      end
      s2u_pkg::PH_ZERO: begin
        ctl_nxt.phase = s2u_pkg::PH_DIGITS;
        if (char_in == CH_UX || char_in == CH_LX) begin
          ctl_nxt.base = s2u_pkg::BASE_HEX;
        end else begin
          // the held leading zero counts as a digit; accumulator is still zero
          ctl_nxt.base = (ctl.base == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_OCT
                                                          : s2u_pkg::BASE_HEX;
          ctl_nxt.digit_seen = 1'b1;
          take = 1'b1;
        end
      end
      s2u_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    // first character after whitespace and sign: latch the radix
    if (sign_path) begin
      if ((cfg_base == s2u_pkg::BASE_AUTO || cfg_base == s2u_pkg::BASE_HEX) &&
          char_in == CH_ZERO) begin
        ctl_nxt.base  = cfg_base;
        ctl_nxt.phase = s2u_pkg::PH_ZERO;
      end else begin
        ctl_nxt.base  = (cfg_base == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_DEC : cfg_base;
        ctl_nxt.phase = s2u_pkg::PH_DIGITS;
        take = 1'b1;
      end
    end

    dv     = digit_value(char_in);
    is_dig = dv < {2'b00, ctl_nxt.base};
    prod   = PW'(acc) * PW'(ctl_nxt.base) + PW'(dv[s2u_pkg::BASE_W-1:0]);

    if (take) begin
      if (!is_dig) begin
        stop_c = 1'b1;
      end else begin
        ctl_nxt.digit_seen = 1'b1;
        if (ctl.overflow || prod[PW-1:VALUE_BITS] != '0) begin
          ctl_nxt.overflow = 1'b1;
        end else begin
          acc_nxt = prod[VALUE_BITS-1:0];
        end
      end
    end

    // last byte without a stop: an assumed terminator follows it
    term = !stop_c && last_char && (ctl.phase != s2u_pkg::PH_DONE);
    if (term && ctl_nxt.phase == s2u_pkg::PH_ZERO) begin
      ctl_nxt.digit_seen = 1'b1;
    end

    stop = stop_c || term;
    if (stop) begin
      ctl_nxt.phase = s2u_pkg::PH_DONE;
    end
  end

endmodule

// ===== rtl/string_to_unsigned_parser_core.sv =====
// Channel   Dir  Payload                                             Transfer
// in_ch     in   char_in[7:0], last_char                             valid && ready
// out_ch    out  value[31:0], stop_offset[7:0], digits_taken, overflowed  valid && ready
// cfg_ch    in   number_base[5:0]                                    valid && ready
//
// One character per cycle sustained while out_ch does not stall; after its character's
// transfer a result passes the input register, then the result register.
// The per-character loop is the parse-state update: one multiply-add of the accumulator
// by the latched radix plus the digit, with its overflow compare.
// rst_n is synchronous: it clears the parse state, position counter and radix (to 0).
// When out_ch stalls, the result register holds and one more character waits in the
// input register; in_ch.ready then drops.
module string_to_unsigned_parser_core #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_CHARS  = 256
) (
  input logic          clk,
  input logic          rst_n,
  s2u_in_if.sink       in_ch,
  s2u_out_if.source    out_ch,
  s2u_cfg_if.sink      cfg_ch
);

  localparam int POS_W  = $clog2(MAX_CHARS + 1);
  localparam int WIDE_W = POS_W + 9;

  // configured radix
  logic [s2u_pkg::BASE_W-1:0] base_cfg_r;

  // input register
  logic                       hold_valid_r;
  logic [s2u_pkg::CHAR_W-1:0] hold_char_r;
  logic                       hold_last_r;

  // parse state
  s2u_pkg::ctl_t              ctl_r;
  logic [VALUE_BITS-1:0]      acc_r;
  logic [POS_W-1:0]           pos_r;

  // result register
  logic                            out_valid_r;
  logic [s2u_pkg::OUT_VALUE_W-1:0] out_value_r;
  logic [s2u_pkg::OFFSET_W-1:0]    out_offset_r;
  logic                            out_digits_r;
  logic                            out_ovf_r;

  s2u_pkg::ctl_t                   ctl_nxt;
  logic [VALUE_BITS-1:0]           acc_nxt;
  logic                            stop;
  logic                            term;
  logic                            advance;
  logic                            fire;
  logic [VALUE_BITS-1:0]           value_w;
  logic [VALUE_BITS+31:0]          value_ext;
  logic [POS_W:0]                  stop_pos;
  logic [WIDE_W-1:0]               stop_wide;
  logic [s2u_pkg::OFFSET_W-1:0]    offset_w;

  s2u_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .char_in   (hold_char_r),
    .last_char (hold_last_r),
    .ctl       (ctl_r),
    .acc       (acc_r),
    .cfg_base  (base_cfg_r),
    .ctl_nxt   (ctl_nxt),
    .acc_nxt   (acc_nxt),
    .stop      (stop),
    .term      (term)
  );

  // advance the held character whenever the result register is free or draining
  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = hold_valid_r && advance;
  assign in_ch.ready  = !hold_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  // saturate on overflow, otherwise negate modulo 2^VALUE_BITS after a minus
  always_comb begin
    if (ctl_nxt.overflow) begin
      value_w = '1;
    end else if (ctl_nxt.minus) begin
      value_w = '0 - acc_nxt;
    end else begin
      value_w = acc_nxt;
    end
    value_ext = {32'd0, value_w};

    stop_pos  = {1'b0, pos_r} + (POS_W + 1)'(term);
    stop_wide = WIDE_W'(stop_pos);
    if (!ctl_nxt.digit_seen) begin
      offset_w = '0;
    end else if (stop_wide > WIDE_W'(255)) begin
      offset_w = '1;
    end else begin
      offset_w = stop_wide[s2u_pkg::OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r <= s2u_pkg::BASE_AUTO;
    end else if (cfg_ch.valid) begin
      base_cfg_r <= cfg_ch.number_base;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      hold_char_r <= in_ch.char_in;
      hold_last_r <= in_ch.last_char;
    end
  end

  // parse state: drop everything after the last byte of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= s2u_pkg::CTL_CLEAR;
      acc_r <= '0;
      pos_r <= '0;
    end else if (fire) begin
      if (hold_last_r) begin
        ctl_r <= s2u_pkg::CTL_CLEAR;
        acc_r <= '0;
        pos_r <= '0;
      end else begin
        ctl_r <= ctl_nxt;
        acc_r <= acc_nxt;
        if (pos_r < POS_W'(MAX_CHARS)) begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && stop;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stop) begin
      out_value_r  <= value_ext[s2u_pkg::OUT_VALUE_W-1:0];
      out_offset_r <= offset_w;
      out_digits_r <= ctl_nxt.digit_seen;
      out_ovf_r    <= ctl_nxt.overflow;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.stop_offset  = out_offset_r;
  assign out_ch.digits_taken = out_digits_r;
  assign out_ch.overflowed   = out_ovf_r;

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_digits_r |-> out_offset_r == '0)
    else $error("stop offset nonzero with no digits taken");

  a_ovf_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_digits_r)
    else $error("overflow reported without any digit");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && hold_last_r |=> ctl_r.phase == s2u_pkg::PH_SKIP && pos_r == '0)
    else $error("parse state not cleared after last byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> hold_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a blocked result");

endmodule

// ===== verif/tb_string_to_unsigned_parser_core.sv =====
`timescale 1ns / 100ps

module tb_string_to_unsigned_parser_core;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 9;
  localparam int MAX_CHARS       = 256;
  localparam int TOTAL_CHARS     = 1350;
  localparam int PHASE_CHARS     = 110;
  localparam int SETTLE_CYCLES   = 4;   // result passes the input register, then the result register
  localparam int END_CYCLES      = 12;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int HOLD_OFF_AT     = 500;
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [s2u_pkg::OUT_VALUE_W-1:0] value;
    logic [s2u_pkg::OFFSET_W-1:0]    stop_offset;
    logic                            digits_taken;
    logic                            overflowed;
  } parse_result_t;

  typedef enum logic {ROW_CHAR, ROW_BASE} row_kind_t;

  // One directed step: a character transfer or a radix write (code holds the radix).
  // Where typed is set, want is the known answer and replaces the prediction.
  typedef struct packed {
    row_kind_t     kind;
    logic [7:0]    code;
    logic          last;
    logic          typed;
    parse_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  s2u_in_if  in_ch ();
  s2u_out_if out_ch ();
  s2u_cfg_if cfg_ch ();

  string_to_unsigned_parser_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser mirror: radix register plus the per-string parse state
  // ---------------------------------------------------------------------------
  logic [s2u_pkg::BASE_W-1:0] base_reg;
  s2u_pkg::phase_t            ps_phase;
  logic [63:0]                ps_acc;
  logic [s2u_pkg::BASE_W-1:0] ps_radix;
  logic                       ps_minus;
  logic                       ps_digit;
  logic                       ps_ovf;
  int                         ps_pos;

  parse_result_t     expected_results[$];
  int                error_count = 0;
  int                live_chars  = 0;   // characters that reached a parser still at work
  logic              burst       = 1'b0;
  logic              hold_off_req  = 1'b0;
  logic              hold_off_done = 1'b0;
  logic [7:0]        text_buf[$];

  function automatic void clear_parse_state();
    ps_phase = s2u_pkg::PH_SKIP;
    ps_acc   = '0;
    ps_radix = s2u_pkg::BASE_AUTO;
    ps_minus = 1'b0;
    ps_digit = 1'b0;
    ps_ovf   = 1'b0;
    ps_pos   = 0;
  endfunction

  // Multiply-add one digit; once the word range is left, keep the overflow sticky.
  function automatic void add_digit(int unsigned v);
    logic [63:0] radix;
    logic [63:0] cutoff;
    logic [63:0] cutlim;
    radix  = (ps_radix != 0) ? 64'(ps_radix) : 64'd10;
    cutoff = WORD_MAX / radix;
    cutlim = WORD_MAX % radix;
    if (ps_ovf || ps_acc > cutoff || (ps_acc == cutoff && 64'(v) > cutlim)) begin
      ps_ovf = 1'b1;
    end else begin
      ps_acc = (ps_acc * radix + 64'(v)) & WORD_MAX;
    end
    ps_digit = 1'b1;
  endfunction

  // Return 1 when c is not a digit of the active radix.
  function automatic logic digit_stops(logic [7:0] c);
    int unsigned v;
    int unsigned radix;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "A" && c <= "Z") v = c - "A" + 10;
    else if (c >= "a" && c <= "z") v = c - "a" + 10;
    else v = 255;
    radix = (ps_radix != 0) ? ps_radix : 10;
    if (v >= radix) return 1'b1;
    add_digit(v);
    return 1'b0;
  endfunction

  function automatic logic feed_char(logic [7:0] c);
    logic [s2u_pkg::BASE_W-1:0] b;
    b = base_reg;
    if (ps_phase == s2u_pkg::PH_SKIP) begin
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return 1'b0;
      ps_phase = s2u_pkg::PH_SIGN;
      if (c == "-") begin
        ps_minus = 1'b1;
        return 1'b0;
      end
      if (c == "+") return 1'b0;
    end
    if (ps_phase == s2u_pkg::PH_SIGN) begin
      // radix is latched here, at the first character past whitespace and sign
      if ((b == s2u_pkg::BASE_AUTO || b == s2u_pkg::BASE_HEX) && c == "0") begin
        ps_radix = b;
        ps_phase = s2u_pkg::PH_ZERO;
        return 1'b0;
      end
      ps_radix = (b == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_DEC : b;
      ps_phase = s2u_pkg::PH_DIGITS;
      return digit_stops(c);
    end
    if (ps_phase == s2u_pkg::PH_ZERO) begin
      ps_phase = s2u_pkg::PH_DIGITS;
      if (c == "x" || c == "X") begin
        ps_radix = s2u_pkg::BASE_HEX;
        return 1'b0;
      end
      // the held leading zero becomes a digit of octal (auto) or hex
      ps_radix = (ps_radix == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_OCT : s2u_pkg::BASE_HEX;
      add_digit(0);
      return digit_stops(c);
    end
    return digit_stops(c);
  endfunction

  // Advance the mirror by one transferred character; return 1 with r when a result is due.
  function automatic logic predict_char(logic [7:0] c, logic lst, output parse_result_t r);
    int          stop_at;
    logic        stopped;
    logic [63:0] neg;
    stop_at = ps_pos;
    stopped = 1'b0;
    r       = '0;
    if (ps_phase != s2u_pkg::PH_DONE) begin
      stopped = feed_char(c);
      if (!stopped && lst) begin
        // a string that ends without a stop gets a terminator one place on
        stop_at = ps_pos + 1;
        void'(feed_char(8'h00));
        stopped = 1'b1;
      end
      if (stopped) begin
        neg = 64'd0 - ps_acc;
        if (ps_ovf) r.value = WORD_MAX[31:0];
        else if (ps_minus) r.value = neg[31:0];
        else r.value = ps_acc[31:0];
        r.stop_offset  = !ps_digit ? 8'd0 : (stop_at > 255) ? 8'd255 : 8'(stop_at);
        r.digits_taken = ps_digit;
        r.overflowed   = ps_ovf;
        ps_phase = s2u_pkg::PH_DONE;
      end
    end
    if (lst) clear_parse_state();
    else if (ps_pos < MAX_CHARS) ps_pos++;
    return stopped;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] digit_char(int unsigned v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes at the falling edge, handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic lst, input logic typed,
                           input parse_result_t want);
    int            gap;
    parse_result_t got;
    gap = burst ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_in   <= c;
    in_ch.last_char <= lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (ps_phase != s2u_pkg::PH_DONE) live_chars++;
    if (predict_char(c, lst, got)) expected_results.push_back(typed ? want : got);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe settle.
  task automatic drain_input(input int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_base(input logic [s2u_pkg::BASE_W-1:0] b);
    drain_input(SETTLE_CYCLES);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.number_base <= b;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    base_reg = b;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  plan_row_t directed_plan [0:27] = '{
    // single digit ended by the last flag, right after reset (auto radix)
    '{ROW_CHAR, "7",   1'b1, 1'b1, '{32'd7, 8'd1, 1'b1, 1'b0}},
    // whitespace and minus sign
    '{ROW_CHAR, " ",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "-",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "1",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "2",   1'b1, 1'b1, '{32'hFFFF_FFF4, 8'd4, 1'b1, 1'b0}},
    // hex prefix with no hex digit behind it
    '{ROW_CHAR, "0",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "x",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "g",   1'b1, 1'b1, '{32'd0, 8'd0, 1'b0, 1'b0}},
    // octal by leading zero, NUL stop, then a character ignored until last
    '{ROW_CHAR, "0",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "1",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "7",   1'b0, 1'b0, '0},
    '{ROW_CHAR, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CHAR, "Z",   1'b1, 1'b0, '0},
    // widest legal radix, saturate on overflow
    '{ROW_BASE, 8'd36, 1'b0, 1'b0, '0},
    '{ROW_CHAR, "Z",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "Z",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "Z",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "z",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "Z",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "z",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "Z",   1'b1, 1'b1, '{32'hFFFF_FFFF, 8'd7, 1'b1, 1'b1}},
    // radix one: only zero is a digit
    '{ROW_BASE, 8'd1,  1'b0, 1'b0, '0},
    '{ROW_CHAR, "0",   1'b0, 1'b0, '0},
    '{ROW_CHAR, "1",   1'b1, 1'b0, '0},
    // top of the register, stop on the top byte
    '{ROW_BASE, 8'd63, 1'b0, 1'b0, '0},
    '{ROW_CHAR, "z",   1'b0, 1'b0, '0},
    '{ROW_CHAR, 8'hFF, 1'b1, 1'b0, '0},
    // whitespace only
    '{ROW_CHAR, 8'h09, 1'b1, 1'b1, '{32'd0, 8'd0, 1'b0, 1'b0}}
  };

  logic [s2u_pkg::BASE_W-1:0] base_plan [0:9] = '{
    s2u_pkg::BASE_AUTO, s2u_pkg::BASE_HEX, 6'd2, s2u_pkg::BASE_DEC, 6'd36,
    s2u_pkg::BASE_OCT, 6'd63, 6'd1, 6'd37, 6'd7
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                         next_switch;
    int                         phase_idx;
    int unsigned                radix;
    int                         ndig;
    logic                       nonzero_lead;
    logic                       long_sent;
    logic [s2u_pkg::BASE_W-1:0] b;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_in      = '0;
    in_ch.last_char    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.number_base = s2u_pkg::BASE_AUTO;
    base_reg           = s2u_pkg::BASE_AUTO;
    clear_parse_state();
    long_sent = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_BASE)
        write_base(directed_plan[i].code[s2u_pkg::BASE_W-1:0]);
      else
        send_char(directed_plan[i].code, directed_plan[i].last, directed_plan[i].typed,
                  directed_plan[i].want);
    end

    next_switch = live_chars;
    phase_idx   = 0;
    while (live_chars < TOTAL_CHARS) begin
      // Advance to the next radix once this phase has seen enough characters.
      if (live_chars >= next_switch) begin
        if (phase_idx < 10) b = base_plan[phase_idx];
        else if ($urandom_range(0, 3) == 0) b = 6'($urandom_range(0, 63));
        else b = 6'($urandom_range(2, 36));
        write_base(b);
        phase_idx++;
        next_switch += PHASE_CHARS;
        if (b == s2u_pkg::BASE_DEC && !long_sent) begin
          // run the position counter into saturation with leading zeros
          long_sent = 1'b1;
          text_buf.delete();
          repeat (270) text_buf.push_back("0");
          text_buf.push_back("4");
          text_buf.push_back("2");
          send_text();
        end
      end

      // Ask the receiver for a long hold-off; keep offering so the block backs up.
      if (!hold_off_req && live_chars >= HOLD_OFF_AT) hold_off_req = 1'b1;

      text_buf.delete();
      burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: raw bytes
        repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        // well-formed number with random content: space, sign, prefix, digits, stop
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
          text_buf.push_back(($urandom_range(0, 5) == 0) ? " " : 8'($urandom_range(9, 13)));
        case ($urandom_range(0, 3))
          0:       text_buf.push_back("-");
          1:       text_buf.push_back("+");
          default: ;
        endcase
        radix        = (base_reg == s2u_pkg::BASE_AUTO) ? 10 :
                       (base_reg > 36) ? 36 : base_reg;
        nonzero_lead = 1'b0;
        if (base_reg == s2u_pkg::BASE_AUTO || base_reg == s2u_pkg::BASE_HEX) begin
          case ($urandom_range(0, 2))
            0: begin
              text_buf.push_back("0");
              text_buf.push_back($urandom_range(0, 1) ? "x" : "X");
              radix = 16;
            end
            1: begin
              if (base_reg == s2u_pkg::BASE_AUTO) begin
                text_buf.push_back("0");
                radix = 8;
              end
            end
            default: nonzero_lead = (base_reg == s2u_pkg::BASE_AUTO);
          endcase
        end
        if ($urandom_range(0, 9) == 0) ndig = 0;
        else if ($urandom_range(0, 7) == 0) ndig = $urandom_range(20, 40);
        else ndig = $urandom_range(1, 10);
        for (int i = 0; i < ndig; i++)
          text_buf.push_back(digit_char((i == 0 && nonzero_lead) ? $urandom_range(1, 9)
                                                                 : $urandom_range(0, radix - 1)));
        // most strings stop on a non-digit; the rest end on the last flag
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 4))
            0:       text_buf.push_back(8'h00);
            1:       text_buf.push_back(" ");
            2:       text_buf.push_back(".");
            3:       text_buf.push_back(8'($urandom_range(128, 255)));
            default: text_buf.push_back((radix < 36) ? digit_char(radix) : "_");
          endcase
          repeat ($urandom_range(0, 2)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
    end

    burst = 1'b0;
    drain_input(END_CYCLES);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random ready pattern, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int run;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_off_req && !hold_off_done) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      @(negedge clk);
      out_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      run = pick_gap();
      if (run > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: value %0h, stop_offset %0d",
               out_ch.value, out_ch.stop_offset);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.value !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, out_ch.value);
          error_count++;
        end
        if (out_ch.stop_offset !== want.stop_offset) begin
          $error("stop_offset: expected %0d, got %0d", want.stop_offset, out_ch.stop_offset);
          error_count++;
        end
        if (out_ch.digits_taken !== want.digits_taken) begin
          $error("digits_taken: expected %0b, got %0b", want.digits_taken,
                 out_ch.digits_taken);
          error_count++;
        end
        if (out_ch.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, out_ch.overflowed);
          error_count++;
        end
      end
    end
  end

  // Hard stop if the handshakes never complete.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
